[rtl/core/rcr_pkg.sv]
// Package for the rectangle canvas rasteriser: payload structs, operation codes,
// the queued command format and the back-end state encoding. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rcr_pkg;

  // Signed cell coordinate after rounding; holds -4096..4095 and any clip bound.
  localparam int unsigned CRD_W = 14;
  // Row or column index at the largest canvas dimension.
  localparam int unsigned IDX_W = 12;
  // Canvas size count, up to the largest dimension itself.
  localparam int unsigned DIM_W = 13;
  // Configuration data width, the widest register.
  localparam int unsigned CFG_W = 9;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_BG     = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_PAINT,
    KIND_READ,
    KIND_REPLY
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAINT,
    ST_READ,
    ST_RDOUT
  } st_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic               filled;
    logic signed [19:0] corner_x;
    logic signed [19:0] corner_y;
    logic signed [19:0] rect_width;
    logic signed [19:0] rect_height;
    logic [7:0]         paint_char;
    logic [7:0]         read_row;
    logic [7:0]         read_col;
  } item_t;

  typedef struct packed {
    logic       status;
    logic [7:0] cell_char;
  } result_t;

  // Canvas settings in force, sizes already limited to 1..maximum.
  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [7:0]       bg;
  } canvas_cfg_t;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    kind_e                   kind;
    logic                    status;
    logic                    fill;
    logic                    read_ok;
    logic [7:0]              pchar;
    logic [IDX_W-1:0]        r0;
    logic [IDX_W-1:0]        r1;
    logic [IDX_W-1:0]        c0;
    logic [IDX_W-1:0]        c1;
    logic signed [CRD_W-1:0] top;
    logic signed [CRD_W-1:0] bottom;
    logic signed [CRD_W-1:0] left;
    logic signed [CRD_W-1:0] right;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/core/rcr_front.sv]
// Front end: rounds and clips a rectangle, classifies each item into a command.
// Depends on rcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcr_front (
  input  rcr_pkg::item_t       item_i,
  input  rcr_pkg::canvas_cfg_t cfg_i,
  output rcr_pkg::cmd_t        cmd_o
);
  import rcr_pkg::*;

  logic [20:0] xc, yc, xr, yb;
  logic signed [CRD_W-1:0] left, top, right, bottom;
  logic signed [CRD_W-1:0] wmax, hmax, r0, r1, c0, c1;
  logic reject, empty, read_ok;

  // ceil(v) = floor(v + 255) in Q8, floor is an arithmetic shift
  assign xc = {item_i.corner_x[19], item_i.corner_x} + 21'd255;
  assign yc = {item_i.corner_y[19], item_i.corner_y} + 21'd255;
  assign xr = {item_i.corner_x[19], item_i.corner_x}
            + {item_i.rect_width[19], item_i.rect_width};
  assign yb = {item_i.corner_y[19], item_i.corner_y}
            + {item_i.rect_height[19], item_i.rect_height};

  assign left   = CRD_W'($signed(xc) >>> 8);
  assign top    = CRD_W'($signed(yc) >>> 8);
  assign right  = CRD_W'($signed(xr) >>> 8);
  assign bottom = CRD_W'($signed(yb) >>> 8);

  assign wmax = $signed({1'b0, cfg_i.w}) - 14'sd1;
  assign hmax = $signed({1'b0, cfg_i.h}) - 14'sd1;

  assign r0 = top[CRD_W-1]  ? '0 : top;
  assign c0 = left[CRD_W-1] ? '0 : left;
  assign r1 = (bottom > hmax) ? hmax : bottom;
  assign c1 = (right > wmax)  ? wmax : right;

  assign reject  = item_i.rect_width[19] || (item_i.rect_width == '0)
                || item_i.rect_height[19] || (item_i.rect_height == '0);
  assign empty   = (r0 > r1) || (c0 > c1);
  assign read_ok = ({5'd0, item_i.read_row} < cfg_i.h)
                && ({5'd0, item_i.read_col} < cfg_i.w);

  always_comb begin
    cmd_o      = '0;
    cmd_o.kind = KIND_REPLY;
    unique case (op_e'(item_i.operation))
      OP_CLEAR: begin
        // a clear is a filled paint of the whole canvas in use
        cmd_o.kind  = KIND_PAINT;
        cmd_o.fill  = 1'b1;
        cmd_o.pchar = cfg_i.bg;
        cmd_o.r1    = IDX_W'(cfg_i.h - 13'd1);
        cmd_o.c1    = IDX_W'(cfg_i.w - 13'd1);
      end
      OP_DRAW: begin
        if (reject) begin
          cmd_o.status = 1'b1;
        end else if (!empty) begin
          cmd_o.kind   = KIND_PAINT;
          cmd_o.fill   = item_i.filled;
          cmd_o.pchar  = item_i.paint_char;
          cmd_o.r0     = IDX_W'(r0);
          cmd_o.r1     = IDX_W'(r1);
          cmd_o.c0     = IDX_W'(c0);
          cmd_o.c1     = IDX_W'(c1);
          cmd_o.top    = top;
          cmd_o.bottom = bottom;
          cmd_o.left   = left;
          cmd_o.right  = right;
        end
      end
      OP_READ: begin
        cmd_o.kind    = KIND_READ;
        cmd_o.read_ok = read_ok;
        cmd_o.r0      = IDX_W'(item_i.read_row);
        cmd_o.c0      = IDX_W'(item_i.read_col);
      end
      OP_NOP: begin
        cmd_o.kind = KIND_REPLY;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/rcr_queue.sv]
// Two-entry command queue between the front end and the back end.
// Depends on rcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rcr_pkg::cmd_t data_i,
  input  logic          pop_i,
  output rcr_pkg::cmd_t data_o,
  output logic          full_o,
  output logic          empty_o
);
  import rcr_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/rcr_back.sv]
// Back end: owns the canvas memory, sweeps paint commands one cell a cycle,
// serves reads and drives the result register. Depends on rcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcr_back #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  rcr_pkg::cmd_t    cmd_i,
  output logic             pop_o,
  output logic             done_o,
  output rcr_pkg::result_t result_o
);
  import rcr_pkg::*;

  localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned ADDR_W = ROW_W + COL_W;

  logic [7:0] canvas_q [2**ADDR_W];
  logic [7:0] rd_data_q;

  st_e              state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [IDX_W-1:0] row_q, row_d, col_q, col_d;
  logic             done_q, done_d;
  result_t          result_q, result_d;
  logic             mem_we, on_edge;
  logic [ADDR_W-1:0] addr;

  assign addr    = {row_q[ROW_W-1:0], col_q[COL_W-1:0]};
  assign on_edge = ($signed({2'b00, row_q}) == cmd_q.top)
                || ($signed({2'b00, row_q}) == cmd_q.bottom)
                || ($signed({2'b00, col_q}) == cmd_q.left)
                || ($signed({2'b00, col_q}) == cmd_q.right);

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    row_d    = row_q;
    col_d    = col_q;
    done_d   = 1'b0;
    result_d = '0;
    pop_o    = 1'b0;
    mem_we   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          row_d = cmd_i.r0;
          col_d = cmd_i.c0;
          unique case (cmd_i.kind)
            KIND_PAINT: state_d = ST_PAINT;
            KIND_READ:  state_d = ST_READ;
            default: begin
              done_d          = 1'b1;
              result_d.status = cmd_i.status;
            end
          endcase
        end
      end
      ST_PAINT: begin
        mem_we = cmd_q.fill || on_edge;
        if (col_q == cmd_q.c1) begin
          col_d = cmd_q.c0;
          if (row_q == cmd_q.r1) begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            row_d = row_q + IDX_W'(1);
          end
        end else begin
          col_d = col_q + IDX_W'(1);
        end
      end
      ST_READ: begin
        // memory data lands in rd_data_q at this edge
        state_d = ST_RDOUT;
      end
      ST_RDOUT: begin
        done_d             = 1'b1;
        result_d.cell_char = cmd_q.read_ok ? rd_data_q : 8'd0;
        state_d            = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    row_q    <= row_d;
    col_q    <= col_d;
    result_q <= result_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      canvas_q[addr] <= cmd_q.pchar;
    end
    rd_data_q <= canvas_q[addr];
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

[rtl/core/rectangle_canvas_rasterizer.sv]
// Top level of the rectangle canvas rasteriser: configuration registers, front
// end, command queue and back end. Depends on rcr_pkg, rcr_front, rcr_queue, rcr_back.
//
//   channel  | ports                            | transfer
//   ---------+----------------------------------+-------------------------------
//   command  | start_i, busy_o, cmd_i           | edge with start_i & !busy_o
//   result   | done_o, result_o                 | every edge with done_o high
//   config   | cfg_we_i, cfg_idx_i, cfg_data_i  | every edge with cfg_we_i high
//
// An item waits in the queue, then the back end takes it. A clear sweeps
// every cell of the canvas in use and a draw each clipped cell, both then a
// result; a read passes the memory read register, a rejected, empty or unused
// item needs no sweep. The sweep of the single canvas memory port sets the rate.
// busy_o rises only while the two-entry queue is full. Results cannot be
// stalled: done_o is high for one cycle per item, in order of acceptance.
// Reset clears control state only; the canvas holds no valid bits, so a clear
// must come before any read.
`timescale 1ns / 1ps
`default_nettype none

module rectangle_canvas_rasterizer #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  rcr_pkg::item_t            cmd_i,
  output logic                      done_o,
  output rcr_pkg::result_t          result_o,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [rcr_pkg::CFG_W-1:0] cfg_data_i
);
  import rcr_pkg::*;

  localparam logic [DIM_W-1:0] MaxW = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MaxH = DIM_W'(MAX_HEIGHT);

  logic [CFG_W-1:0] width_q, height_q;
  logic [7:0]       bg_q;
  canvas_cfg_t      canvas_cfg;
  cmd_t             front_cmd, queue_cmd;
  logic             push, pop, full, empty;

  // Hold the configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(1);
      height_q <= CFG_W'(1);
      bg_q     <= 8'd32;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        CFG_BG:     bg_q     <= cfg_data_i[7:0];
        CFG_NONE:   ;
      endcase
    end
  end

  // Limit the sizes in use to 1..maximum; zero acts as one.
  always_comb begin
    canvas_cfg.bg = bg_q;
    if (width_q == '0) begin
      canvas_cfg.w = DIM_W'(1);
    end else if (DIM_W'(width_q) > MaxW) begin
      canvas_cfg.w = MaxW;
    end else begin
      canvas_cfg.w = DIM_W'(width_q);
    end
    if (height_q == '0) begin
      canvas_cfg.h = DIM_W'(1);
    end else if (DIM_W'(height_q) > MaxH) begin
      canvas_cfg.h = MaxH;
    end else begin
      canvas_cfg.h = DIM_W'(height_q);
    end
  end

  // Accept a command whenever the queue has room.
  assign busy_o = full;
  assign push   = start_i && !full;

  rcr_front u_front (
    .item_i (cmd_i),
    .cfg_i  (canvas_cfg),
    .cmd_o  (front_cmd)
  );

  rcr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .pop_i   (pop),
    .data_o  (queue_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  rcr_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .cmd_i    (queue_cmd),
    .pop_o    (pop),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

[rtl/core/rcr_checker.sv]
// Port-level checker for the rectangle canvas rasteriser, bound to the top level.
// Depends on rcr_pkg and rectangle_canvas_rasterizer.
`timescale 1ns / 1ps
`default_nettype none

module rcr_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_o,
  input logic             done_o,
  input rcr_pkg::result_t result_o
);
  import rcr_pkg::*;

  logic [2:0] pending_q, pending_d;

  // Count items taken but not yet answered.
  assign pending_d = pending_q + 3'(start_i && !busy_o) - 3'(done_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 3'd0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_no_orphan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> pending_q != 3'd0)
    else $error("result without an outstanding item");

  a_idle_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == 3'd0 |-> !busy_o)
    else $error("busy with nothing outstanding");

  a_full_is_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == 3'd3 |-> busy_o)
    else $error("more items taken than queue and back end can hold");

  a_reject_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status) |-> result_o.cell_char == 8'd0)
    else $error("rejected draw returned a character");

endmodule

bind rectangle_canvas_rasterizer rcr_checker u_rcr_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .done_o   (done_o),
  .result_o (result_o)
);

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for rectangle_canvas_rasterizer: drives commands and
// register writes, predicts each reply from a private canvas copy and checks it.
// Depends on rcr_pkg and the rectangle_canvas_rasterizer RTL.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
  import rcr_pkg::*;

  // One cell in signed Q11.8 units.
  localparam int Q8 = 256;
  // Row pitch of the canvas store, as in the block at its default size.
  localparam int PITCH = 256;
  // Cycle limit past which a run is taken as hung.
  localparam int LIMIT = 2_000_000;

  // Predicts the reply to every command from a copy of the canvas and the
  // register settings, and keeps the replies still to come in order.
  class canvas_scoreboard;
    bit [7:0] cells [0:65535];
    bit       painted [0:65535];
    int       cols;
    int       rows;
    bit [7:0] bg_char;
    result_t  awaited[$];
    int       errors;

    function new();
      cols    = 1;
      rows    = 1;
      bg_char = 8'd32;
      errors  = 0;
    endfunction

    // Sizes of zero act as one, sizes above the maximum act as the maximum.
    function int limit_dim(bit [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > 256) return 256;
      return int'(v);
    endfunction

    // Forget which cells hold data on a size change: cells brought into use
    // count as unwritten until the next clear or draw.
    function void set_reg(cfg_idx_e idx, bit [CFG_W-1:0] val);
      case (idx)
        CFG_WIDTH:  cols = limit_dim(val);
        CFG_HEIGHT: rows = limit_dim(val);
        CFG_BG:     bg_char = val[7:0];
        default: ;
      endcase
      if (idx == CFG_WIDTH || idx == CFG_HEIGHT) begin
        foreach (painted[k]) painted[k] = 1'b0;
      end
    endfunction

    function bit readable(int r, int c);
      return r >= rows || c >= cols || painted[r * PITCH + c];
    endfunction

    function void note_command(item_t it);
      result_t reply;
      longint  x, y, rw, rh;
      longint  left, top, right, bottom;
      longint  r0, r1, c0, c1, i, j;
      reply = '0;
      case (it.operation)
        OP_CLEAR: begin
          for (i = 0; i < rows; i++) begin
            for (j = 0; j < cols; j++) begin
              cells[int'(i * PITCH + j)]   = bg_char;
              painted[int'(i * PITCH + j)] = 1'b1;
            end
          end
        end
        OP_DRAW: begin
          x  = longint'($signed(it.corner_x));
          y  = longint'($signed(it.corner_y));
          rw = longint'($signed(it.rect_width));
          rh = longint'($signed(it.rect_height));
          if (rw <= 0 || rh <= 0) begin
            reply.status = 1'b1;
          end else begin
            // Arithmetic shift floors; ceil is the negated floor of the negation.
            left   = -((-x) >>> 8);
            top    = -((-y) >>> 8);
            right  = (x + rw) >>> 8;
            bottom = (y + rh) >>> 8;
            r0 = top < 0 ? 0 : top;
            r1 = bottom > rows - 1 ? rows - 1 : bottom;
            c0 = left < 0 ? 0 : left;
            c1 = right > cols - 1 ? cols - 1 : right;
            for (i = r0; i <= r1; i++) begin
              for (j = c0; j <= c1; j++) begin
                if (it.filled || i == top || i == bottom || j == left || j == right) begin
                  cells[int'(i * PITCH + j)]   = it.paint_char;
                  painted[int'(i * PITCH + j)] = 1'b1;
                end
              end
            end
          end
        end
        OP_READ: begin
          if (it.read_row < rows && it.read_col < cols) begin
            reply.cell_char = cells[int'(it.read_row) * PITCH + int'(it.read_col)];
          end
        end
        default: ;
      endcase
      awaited.push_back(reply);
    endfunction

    function void check_reply(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: reply with none awaited: status %0d cell_char 0x%02h",
                 $time, got.status, got.cell_char);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
      if (got.cell_char !== want.cell_char) begin
        $display("%0t: cell_char mismatch: expected 0x%02h, actual 0x%02h",
                 $time, want.cell_char, got.cell_char);
        errors++;
      end
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  item_t            cmd_i;
  logic             done_o;
  result_t          result_o;
  logic             cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  canvas_scoreboard board;
  int               cycles = 0;
  // When set, the sender issues back to back with no gaps.
  bit               burst;

  rectangle_canvas_rasterizer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .cmd_i      (cmd_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Check every reply on the edge that ends its cycle; the receiver never stalls.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      board.check_reply(result_o);
    end
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Present a command at the falling edge and hold it until a transfer; then
  // note it for prediction and idle for a random gap unless in a burst.
  task automatic send(input item_t it);
    int gap;
    cmd_i   = it;
    start_i = 1'b1;
    do @(posedge clk_i); while (busy_o);
    board.note_command(it);
    @(negedge clk_i);
    gap = burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Drop start and hold off until every awaited reply has arrived, then let
  // the block settle.
  task automatic drain();
    start_i = 1'b0;
    while (board.outstanding() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write one register; only ever called with the block idle.
  task automatic write_reg(input cfg_idx_e idx, input int val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = CFG_W'(val);
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_NONE;
    board.set_reg(idx, CFG_W'(val));
  endtask

  function automatic item_t bare_cmd(input op_e op);
    item_t it;
    it = '0;
    it.operation = op;
    return it;
  endfunction

  function automatic item_t draw_cmd(input bit fill, input int x, input int y,
                                     input int w, input int h, input bit [7:0] ch);
    item_t it;
    it             = bare_cmd(OP_DRAW);
    it.filled      = fill;
    it.corner_x    = 20'(x);
    it.corner_y    = 20'(y);
    it.rect_width  = 20'(w);
    it.rect_height = 20'(h);
    it.paint_char  = ch;
    return it;
  endfunction

  function automatic item_t read_cmd(input int r, input int c);
    item_t it;
    it          = bare_cmd(OP_READ);
    it.read_row = 8'(r);
    it.read_col = 8'(c);
    return it;
  endfunction

  // A size beyond the largest canvas, or the largest itself.
  function automatic int big_dim();
    case ($urandom_range(0, 2))
      0:       return 256;
      1:       return $urandom_range(257, 510);
      default: return 511;
    endcase
  endfunction

  // Mostly well-formed draws near the canvas and reads of written cells, the
  // rest noise: full-range draws, unused operations, stray clears.
  function automatic item_t random_cmd();
    item_t it;
    int    pick;
    int    lim_r;
    int    lim_c;
    it.operation   = OP_NOP;
    it.filled      = 1'($urandom);
    it.corner_x    = 20'($urandom);
    it.corner_y    = 20'($urandom);
    it.rect_width  = 20'($urandom);
    it.rect_height = 20'($urandom);
    it.paint_char  = 8'($urandom);
    it.read_row    = 8'($urandom);
    it.read_col    = 8'($urandom);
    pick  = $urandom_range(0, 99);
    lim_r = board.rows > 255 ? 255 : board.rows;
    lim_c = board.cols > 255 ? 255 : board.cols;
    if (pick < 4) begin
      it.operation = OP_CLEAR;
    end else if (pick < 54) begin
      it.operation = OP_DRAW;
      it.corner_x  = 20'(int'($urandom_range(0, (board.cols + 6) * Q8)) - 3 * Q8);
      it.corner_y  = 20'(int'($urandom_range(0, (board.rows + 6) * Q8)) - 3 * Q8);
      it.rect_width  = 20'(($urandom_range(0, 9) == 0)
                           ? -int'($urandom_range(0, 2 * Q8))
                           : int'($urandom_range(1, (board.cols + 4) * Q8)));
      it.rect_height = 20'(($urandom_range(0, 9) == 0)
                           ? -int'($urandom_range(0, 2 * Q8))
                           : int'($urandom_range(1, (board.rows + 4) * Q8)));
    end else if (pick < 61) begin
      it.operation = OP_DRAW;
    end else if (pick < 92) begin
      it.operation = OP_READ;
      if ($urandom_range(0, 7) != 0) begin
        it.read_row = 8'($urandom_range(0, lim_r));
        it.read_col = 8'($urandom_range(0, lim_c));
      end
      // Never read a cell that holds no data yet; clear instead.
      if (!board.readable(int'(it.read_row), int'(it.read_col))) begin
        it.operation = OP_CLEAR;
      end
    end
    return it;
  endfunction

  initial begin
    int ph;
    int wv;
    int hv;
    int axis;
    board      = new();
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    cmd_i      = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_NONE;
    cfg_data_i = '0;
    burst      = 1'b1;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Sizes of zero: a one-cell canvas with a zero background.
    write_reg(CFG_WIDTH, 0);
    write_reg(CFG_HEIGHT, 0);
    write_reg(CFG_BG, 0);
    send(bare_cmd(OP_CLEAR));
    send(read_cmd(0, 0));
    send(read_cmd(0, 1));
    send(draw_cmd(1'b1, -Q8 / 2, -Q8 / 2, Q8, Q8, 8'hA5));
    send(read_cmd(0, 0));
    drain();

    // Directed checks of rounding, outline, clipping and rejection on a 20 x 12 canvas.
    write_reg(CFG_WIDTH, 20);
    write_reg(CFG_HEIGHT, 12);
    write_reg(CFG_BG, 8'h2E);
    burst = 1'b0;
    send(bare_cmd(OP_CLEAR));
    send(draw_cmd(1'b1, 2 * Q8, 1 * Q8, 5 * Q8, 3 * Q8, 8'h41));
    send(read_cmd(4, 7));
    // Fractional corners: ceil on the top-left, floor on the far edges.
    send(draw_cmd(1'b0, 3 * Q8 + 128, 2 * Q8 + 64, 6 * Q8 + 192, 5 * Q8 + 128, 8'h72));
    send(read_cmd(5, 6));
    send(read_cmd(5, 10));
    // Negative corner clipped at the top-left.
    send(draw_cmd(1'b0, -2 * Q8 - 128, -Q8 - 192, 6 * Q8, 4 * Q8, 8'h52));
    send(read_cmd(2, 0));
    send(read_cmd(1, 1));
    // Rejected sizes: zero width, negative height, most negative both.
    send(draw_cmd(1'b1, 0, 0, 0, 4 * Q8, 8'h58));
    send(draw_cmd(1'b1, 0, 0, 4 * Q8, -Q8, 8'h58));
    send(draw_cmd(1'b0, 0, 0, -524288, -524288, 8'h58));
    // Outline running past the bottom-right corner.
    send(draw_cmd(1'b0, 17 * Q8, 10 * Q8, 10 * Q8, 10 * Q8, 8'h2B));
    send(read_cmd(10, 19));
    // Field extremes that land wholly off the canvas.
    send(draw_cmd(1'b1, 524287, 524287, 524287, 524287, 8'h5A));
    send(draw_cmd(1'b1, -524288, -524288, 524287, 524287, 8'hFF));
    // Narrower than a cell so nothing is covered, then a one-column sliver.
    send(draw_cmd(1'b1, 5 * Q8 + 128, 0, 64, 12 * Q8, 8'h65));
    send(draw_cmd(1'b1, 4 * Q8, 6 * Q8, 1, 3 * Q8, 8'h00));
    send(read_cmd(8, 4));
    send(bare_cmd(OP_NOP));
    // Reads at and beyond the canvas limits.
    send(read_cmd(12, 0));
    send(read_cmd(0, 20));
    send(read_cmd(255, 255));
    send(read_cmd(11, 19));
    drain();

    // Largest canvas, height given beyond the maximum.
    write_reg(CFG_WIDTH, 256);
    write_reg(CFG_HEIGHT, 511);
    write_reg(CFG_BG, 8'hFF);
    send(bare_cmd(OP_CLEAR));
    send(read_cmd(255, 255));
    send(draw_cmd(1'b1, 0, 0, 256 * Q8, 256 * Q8, 8'h00));
    send(read_cmd(128, 200));
    send(draw_cmd(1'b0, 0, 0, 255 * Q8, 255 * Q8, 8'h23));
    send(read_cmd(0, 37));
    send(read_cmd(255, 0));
    send(read_cmd(100, 100));
    send(draw_cmd(1'b0, 10 * Q8 + 128, 20 * Q8 + 64, 100 * Q8, 50 * Q8, 8'h6F));
    send(read_cmd(21, 11));
    drain();

    // Random phases, each with fresh settings and opened by a clear.
    for (ph = 0; ph < 4; ph++) begin
      axis = $urandom_range(0, 2);
      wv   = $urandom_range(0, 40);
      hv   = $urandom_range(0, 40);
      if (axis == 1) begin
        wv = big_dim();
        hv = $urandom_range(0, 6);
      end else if (axis == 2) begin
        hv = big_dim();
        wv = $urandom_range(0, 6);
      end
      write_reg(CFG_WIDTH, wv);
      write_reg(CFG_HEIGHT, hv);
      write_reg(CFG_BG, $urandom_range(0, 255));
      burst = ($urandom_range(0, 2) == 0);
      send(bare_cmd(OP_CLEAR));
      repeat (16) begin
        send(random_cmd());
        // Now and then hold the sender until the pipeline is empty.
        if ($urandom_range(0, 11) == 0) drain();
      end
      drain();
    end

    start_i = 1'b0;
    while (board.outstanding() != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
